### rtl/rdiv_pkg.sv
// Package for the restoring divider: datapath width, transaction structs,
// and the single-round restoring step shared by the pipeline stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdiv_pkg;

  localparam int WIDTH = 8;
  localparam int ROUNDS_PER_STAGE_DEF = 2;

  typedef struct packed {
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } operands_t;

  typedef struct packed {
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
    logic             divide_by_zero;
  } result_t;

  // work: dividend bits not yet consumed in the high part, quotient bits
  // shifted in from the bottom; holds the quotient after WIDTH rounds.
  typedef struct packed {
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] work;
    logic [WIDTH-1:0] den;
    logic             dbz;
  } stage_t;

  function automatic stage_t div_round(stage_t s);
    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;
    stage_t           r;
    shifted = {s.rem, s.work[WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, s.den};
    r       = s;
    r.work  = {s.work[WIDTH-2:0], ~diff[WIDTH+1]};
    if (!diff[WIDTH+1]) begin
      r.rem = diff[WIDTH-1:0];
    end else begin
      r.rem = shifted[WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/restoring_divider_unit.sv
// Pipelined unsigned restoring divider, top level. Depends on rdiv_pkg, rdiv_stage.
// Each operand transaction passes through every stage register before result valid;
// each stage register follows ROUNDS_PER_STAGE restoring rounds.
// Throughput: one transaction per cycle while result_ready stays high; each stage holds its own transaction.
// Reset clears all stage valid bits; the pipeline is empty after reset.
`timescale 1ns / 1ps
`default_nettype none

module restoring_divider_unit
  import rdiv_pkg::*;
#(
  parameter int ROUNDS_PER_STAGE = ROUNDS_PER_STAGE_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      operand_valid,
  output logic           operand_ready,
  input  wire operands_t operands,
  output logic           result_valid,
  input  wire logic      result_ready,
  output result_t        result
);

  // ROUNDS_PER_STAGE must divide WIDTH.
  localparam int NUM_STAGES = WIDTH / ROUNDS_PER_STAGE;

  logic   valid [NUM_STAGES+1];
  logic   ready [NUM_STAGES+1];
  stage_t data  [NUM_STAGES+1];

  always_comb begin
    data[0]      = '0;
    data[0].rem  = '0;
    data[0].work = operands.dividend;
    data[0].den  = operands.divisor;
    data[0].dbz  = (operands.divisor == '0);
  end

  assign valid[0]      = operand_valid;
  assign operand_ready = ready[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    rdiv_stage #(
      .ROUNDS (ROUNDS_PER_STAGE)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[g]),
      .in_ready  (ready[g]),
      .in_data   (data[g]),
      .out_valid (valid[g+1]),
      .out_ready (ready[g+1]),
      .out_data  (data[g+1])
    );
  end

  assign ready[NUM_STAGES] = result_ready;
  assign result_valid      = valid[NUM_STAGES];

  always_comb begin
    result.quotient       = data[NUM_STAGES].work;
    result.remainder      = data[NUM_STAGES].rem;
    result.divide_by_zero = data[NUM_STAGES].dbz;
  end

endmodule

`default_nettype wire

### rtl/rdiv_stage.sv
// One pipeline stage of the restoring divider: ROUNDS restoring steps
// followed by a valid/ready register. Depends on rdiv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdiv_stage
  import rdiv_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_PER_STAGE_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire stage_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output stage_t      out_data
);

  logic   valid;
  stage_t data;
  stage_t data_next;

  always_comb begin
    stage_t acc;
    acc = in_data;
    for (int i = 0; i < ROUNDS; i++) begin
      acc = div_round(acc);
    end
    data_next = acc;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

`default_nettype wire

### tb/sv/rdiv_result_checker.sv
// Result checker for restoring_divider_unit: predicts quotient, remainder and
// the zero-divisor flag for every accepted operand transaction and compares them
// in order with the result transactions. Depends on rdiv_pkg.
`timescale 1ns / 1ps

module rdiv_result_checker
  import rdiv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      operand_valid,
  input  logic      operand_ready,
  input  operands_t operands,
  input  logic      result_valid,
  input  logic      result_ready,
  input  result_t   result,
  output int        mismatches,
  output int        outstanding
);

  result_t pending_divisions[$];

  // Shift-subtract with a WIDTH+1 bit partial remainder.
  function automatic result_t restore_divide(operands_t op);
    logic [WIDTH:0]   partial;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] quo;
    result_t          res;
    rem = '0;
    quo = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      partial = {rem, op.dividend[i]};
      if (partial >= {1'b0, op.divisor}) begin
        rem = partial[WIDTH-1:0] - op.divisor;
        quo = {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem = partial[WIDTH-1:0];
        quo = {quo[WIDTH-2:0], 1'b0};
      end
    end
    res.quotient       = quo;
    res.remainder      = rem;
    res.divide_by_zero = (op.divisor == '0);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_divisions.size() == 0) begin
          $display("%0t: unexpected result transaction, got q=%0d r=%0d dbz=%0b",
                   $time, result.quotient, result.remainder, result.divide_by_zero);
          mismatches++;
        end else begin
          want = pending_divisions.pop_front();
          if (result.quotient !== want.quotient) begin
            $display("%0t: quotient expected %0d, got %0d",
                     $time, want.quotient, result.quotient);
            mismatches++;
          end
          if (result.remainder !== want.remainder) begin
            $display("%0t: remainder expected %0d, got %0d",
                     $time, want.remainder, result.remainder);
            mismatches++;
          end
          if (result.divide_by_zero !== want.divide_by_zero) begin
            $display("%0t: divide_by_zero expected %0b, got %0b",
                     $time, want.divide_by_zero, result.divide_by_zero);
            mismatches++;
          end
        end
      end
      if (operand_valid && operand_ready) begin
        pending_divisions.push_back(restore_divide(operands));
      end
      outstanding = pending_divisions.size();
    end
  end

endmodule

### tb/sv/tb_restoring_divider_unit.sv
// Testbench top for restoring_divider_unit: drives directed corner operands and
// random operand transactions under several idle/stall mixes and gives the verdict.
// Depends on rdiv_pkg, restoring_divider_unit and rdiv_result_checker.
`timescale 1ns / 1ps

module tb_restoring_divider_unit;
  import rdiv_pkg::*;

  localparam int PHASE_ITEMS = 440;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      operand_valid = 1'b0;
  logic      operand_ready;
  operands_t operands = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  result_t   result;
  int        mismatches;
  int        outstanding;

  int send_idle_pct = 0;
  int stall_pct = 0;

  logic [2*WIDTH-1:0] corner_cases[] = '{
    16'h00_00, 16'hFF_00, 16'h00_FF, 16'hFF_FF, 16'hFF_01, 16'h01_FF,
    16'h80_80, 16'hC8_07, 16'h07_C8, 16'h00_01, 16'hFF_80, 16'h80_FF,
    16'hAA_55, 16'h55_AA, 16'h64_0A, 16'h01_01, 16'hFE_FF, 16'hFF_FE,
    16'h7F_80, 16'h80_7F, 16'h01_00, 16'h80_01, 16'hFF_02, 16'h12_34
  };

  restoring_divider_unit uut (
    .clk          (clk),
    .rst          (rst),
    .operand_valid(operand_valid),
    .operand_ready(operand_ready),
    .operands     (operands),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  rdiv_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .operand_valid(operand_valid),
    .operand_ready(operand_ready),
    .operands     (operands),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_operands(input operands_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      operand_valid <= 1'b0;
      @(posedge clk);
    end
    operand_valid <= 1'b1;
    operands      <= op;
    do @(posedge clk); while (!operand_ready);
  endtask

  function automatic operands_t random_operands();
    operands_t op;
    logic [WIDTH-1:0] picks[5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    op.dividend = WIDTH'($urandom);
    op.divisor  = WIDTH'($urandom);
    case ($urandom_range(9))
      0: op.divisor = '0;
      1: op.divisor = WIDTH'($urandom_range(3, 1));
      2: op.divisor = op.dividend ^ WIDTH'($urandom_range(3));
      3: op.dividend = WIDTH'($urandom_range(op.divisor));
      4: begin
        op.dividend = picks[$urandom_range(4)];
        op.divisor  = picks[$urandom_range(4)];
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic run_phase(input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (PHASE_ITEMS) send_operands(random_operands());
  endtask

  initial begin
    int wait_cycles;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_cases[k]) send_operands(operands_t'(corner_cases[k]));

    run_phase(0, 0);
    run_phase(49, 0);
    run_phase(0, 49);
    run_phase(35, 35);
    operand_valid <= 1'b0;
    @(posedge clk);

    wait_cycles = 0;
    while (outstanding != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (outstanding != 0) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      if (mismatches == 0 && outstanding == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
      $finish;
    end
  end

endmodule
